### rtl/spi_register_access_master_defines.svh
// assertion macros for the spi register access master rtl
// no dependencies; included inside the sra_back module body, which checks its own logic
`ifndef SPI_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define SPI_REGISTER_ACCESS_MASTER_DEFINES_SVH

// checked only while out of reset
`define SRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define SRA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/sra_pkg.sv
// shared types and constants for the spi register access master
// no dependencies
`timescale 1ns / 1ps

package sra_pkg;

    localparam int OPCODE_BITS = 8;
    localparam int ADDR_BITS   = 16;
    localparam int DATA_BITS   = 8;
    localparam int FRAME_BITS  = OPCODE_BITS + ADDR_BITS + DATA_BITS;
    localparam int CNT_W       = $clog2(FRAME_BITS + 1);
    localparam int READ_START  = OPCODE_BITS + ADDR_BITS;

    localparam int ACTION_W = 2;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [ACTION_W-1:0] ACTION_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OPCODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_OPCODE  = 1'd1;

    localparam logic [OPCODE_BITS-1:0] WRITE_OPCODE_RESET = 8'd240;
    localparam logic [OPCODE_BITS-1:0] READ_OPCODE_RESET  = 8'd15;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef logic [1:0] op_t;
    localparam op_t OP_TICK     = 2'd0;
    localparam op_t OP_WR_START = 2'd1;
    localparam op_t OP_READ     = 2'd2;

    typedef struct packed {
        op_t                   op;
        logic [FRAME_BITS-1:0] frame;
        logic                  miso;
    } sra_item_t;

    typedef struct packed {
        logic                 chip_select;
        logic                 mosi;
        logic                 clock_pulse;
        logic                 done_res;
        logic [DATA_BITS-1:0] read_data;
        logic                 rejected;
    } sra_result_t;

endpackage

### rtl/spi_register_access_master.sv
// spi register access master: each input beat is registered in a queue slot, then its result beat in res_reg
// throughput one beat per clock unless m_tready stalls; each beat is one bit period of the frame
// a start beat latches opcode, address and, for a write, data; 32 tick beats clock out the frame
// the decoded beat queue lets input keep flowing while a result beat waits on m_tready
// aresetn is synchronous, active low: idle, queue empty, opcodes back to 0xf0 and 0x0f
`timescale 1ns / 1ps

module spi_register_access_master #(
    parameter int QUEUE_DEPTH = sra_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sra_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // address[15:0], write_data[23:16], miso_bit[24]
    input  logic [sra_pkg::ACTION_W-1:0]  s_tuser,   // action[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // chip_select[0], mosi[1], clock_pulse[2],
                                                     // read_data[10:3], rejected[11]
    output logic                          m_tlast    // done_res
);
    import sra_pkg::*;

    sra_item_t front_item;
    sra_item_t q_item;
    logic      q_valid;
    logic      q_ready;

    sra_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .action     (s_tuser),
        .address    (s_tdata[15:0]),
        .write_data (s_tdata[23:16]),
        .miso_bit   (s_tdata[24]),
        .item       (front_item)
    );

    sra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    sra_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/sra_front.sv
// front end: holds the opcode registers, decodes each input beat and builds the frame word
// depends on sra_pkg
`timescale 1ns / 1ps

module sra_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sra_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [sra_pkg::ACTION_W-1:0]  action,
    input  logic [15:0]                   address,
    input  logic [7:0]                    write_data,
    input  logic                          miso_bit,
    output sra_pkg::sra_item_t            item
);
    import sra_pkg::*;

    logic [OPCODE_BITS-1:0] write_opcode_reg;
    logic [OPCODE_BITS-1:0] read_opcode_reg;
    logic [ADDR_BITS-1:0]   addr_field;
    logic [DATA_BITS-1:0]   tail_field;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_opcode_reg <= WRITE_OPCODE_RESET;
            read_opcode_reg  <= READ_OPCODE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WRITE_OPCODE: write_opcode_reg <= cfg_wdata[OPCODE_BITS-1:0];
                CFG_READ_OPCODE:  read_opcode_reg  <= cfg_wdata[OPCODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign addr_field = ADDR_BITS'(address);

    always_comb begin
        item       = '0;
        item.miso  = miso_bit;
        tail_field = DATA_BITS'(write_data);
        case (action)
            ACTION_WRITE: begin
                item.op    = OP_WR_START;
                item.frame = {write_opcode_reg, addr_field, tail_field};
            end
            ACTION_READ: begin
                // mosi parks on the last address bit while miso comes in
                tail_field = {DATA_BITS{addr_field[0]}};
                item.op    = OP_READ;
                item.frame = {read_opcode_reg, addr_field, tail_field};
            end
            default: begin
                item.op = OP_TICK;
            end
        endcase
    end

endmodule

### rtl/sra_queue.sv
// short fifo of decoded beats between front end and frame engine
// depends on sra_pkg
`timescale 1ns / 1ps

module sra_queue #(
    parameter int DEPTH = sra_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sra_pkg::sra_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output sra_pkg::sra_item_t out_item
);
    import sra_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    sra_item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0]   count_reg, count_next;
    logic                 push, pop;

    assign in_ready  = (count_reg != CNT_W_Q'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/sra_back.sv
// frame engine: runs the spi frame one beat per cycle, unless m_tready stalls it, into a registered output beat
// depends on sra_pkg and spi_register_access_master_defines.svh
`timescale 1ns / 1ps

module sra_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  sra_pkg::sra_item_t            q_item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,
    output logic                          m_tlast
);
    import sra_pkg::*;
    `include "spi_register_access_master_defines.svh"

    localparam logic [CNT_W-1:0] LAST_BIT   = CNT_W'(FRAME_BITS - 1);
    localparam logic [CNT_W-1:0] READ_FIRST = CNT_W'(READ_START);

    logic                  busy_reg, busy_next;
    logic                  is_read_reg, is_read_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]      bits_sent_reg, bits_sent_next;
    logic [DATA_BITS-1:0]  in_shift_reg, in_shift_next;
    logic                  mosi_level_reg, mosi_level_next;
    logic                  m_tvalid_reg;
    sra_result_t           res_reg, res;
    logic                  pop;

    assign q_ready = !m_tvalid_reg || m_tready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        busy_next       = busy_reg;
        is_read_next    = is_read_reg;
        shift_next      = shift_reg;
        bits_sent_next  = bits_sent_reg;
        in_shift_next   = in_shift_reg;
        mosi_level_next = mosi_level_reg;
        res             = '0;
        res.mosi        = mosi_level_reg;
        if (pop) begin
            if (q_item.op == OP_WR_START || q_item.op == OP_READ) begin
                res.chip_select = 1'b1;
                if (busy_reg) begin
                    res.rejected = 1'b1;
                end else begin
                    shift_next     = q_item.frame;
                    busy_next      = 1'b1;
                    is_read_next   = (q_item.op == OP_READ);
                    bits_sent_next = '0;
                    in_shift_next  = '0;
                end
            end else if (busy_reg) begin
                res.chip_select = 1'b1;
                res.clock_pulse = 1'b1;
                mosi_level_next = shift_reg[FRAME_BITS-1];
                res.mosi        = mosi_level_next;
                shift_next      = {shift_reg[FRAME_BITS-2:0], 1'b0};
                if (is_read_reg && bits_sent_reg >= READ_FIRST) begin
                    in_shift_next = {in_shift_reg[DATA_BITS-2:0], q_item.miso};
                end
                if (bits_sent_reg == LAST_BIT) begin
                    res.done_res   = 1'b1;
                    busy_next      = 1'b0;
                    bits_sent_next = '0;
                    if (is_read_reg) begin
                        res.read_data = in_shift_next;
                    end
                end else begin
                    bits_sent_next = bits_sent_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            is_read_reg    <= 1'b0;
            bits_sent_reg  <= '0;
            mosi_level_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            is_read_reg    <= is_read_next;
            bits_sent_reg  <= bits_sent_next;
            mosi_level_reg <= mosi_level_next;
            if (pop) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        in_shift_reg <= in_shift_next;
        if (pop) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = res_reg.done_res;
    assign m_tdata  = {4'b0000, res_reg.rejected, res_reg.read_data,
                       res_reg.clock_pulse, res_reg.mosi, res_reg.chip_select};

    `SRA_ASSERT(a_idle_count_clear, !busy_reg |-> bits_sent_reg == '0,
                "bit count left nonzero while idle")
    `SRA_ASSERT(a_last_bit_ends,
                (pop && q_item.op == OP_TICK && busy_reg && bits_sent_reg == LAST_BIT)
                |=> (!busy_reg && m_tvalid_reg && m_tlast),
                "last bit did not end frame with done")
    `SRA_ASSERT(a_reject_keeps_frame,
                (pop && busy_reg && q_item.op != OP_TICK)
                |=> (busy_reg && $stable(bits_sent_reg) && $stable(shift_reg)),
                "rejected start disturbed active frame")
    `SRA_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (!busy_reg && !m_tvalid_reg),
                       "engine not idle after reset")

endmodule
